// ----- sv/spd_pkg.sv -----
// Shared types and constants of the slotted page directory.
`timescale 1ns / 1ps

package spd_pkg;

	// Fixed field widths of the request and result beats.
	localparam int OP_W      = 4;
	localparam int PAGE_W    = 32;
	localparam int SLOT_IN_W = 10;
	localparam int SIZE_W    = 13;
	localparam int STATUS_W  = 3;
	localparam int ITER_W    = 12;

	// Each slot entry takes four bytes of the page.
	localparam int SLOT_BYTES = 4;

	// Iterator marks: before the first slot, and the saturation point.
	localparam logic [ITER_W-1:0] ITER_BEFORE = 12'hFFF;
	localparam logic [ITER_W-1:0] ITER_LAST   = 12'hFFE;

	localparam logic [OP_W-1:0] OP_FORMAT     = 4'd0;
	localparam logic [OP_W-1:0] OP_CAN_FIT    = 4'd1;
	localparam logic [OP_W-1:0] OP_INSERT     = 4'd2;
	localparam logic [OP_W-1:0] OP_GET        = 4'd3;
	localparam logic [OP_W-1:0] OP_GET_SIZE   = 4'd4;
	localparam logic [OP_W-1:0] OP_DELETE     = 4'd5;
	localparam logic [OP_W-1:0] OP_UPDATE     = 4'd6;
	localparam logic [OP_W-1:0] OP_ITER_RESET = 4'd7;
	localparam logic [OP_W-1:0] OP_ITER_NEXT  = 4'd8;

	localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PAGE   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_UNUSED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SIZE   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_SPACE  = 3'd5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_PLACE,
		S_ITRD,
		S_ITCHK
	} state_t;

	// Commands from the sequencer to the space allocator.
	typedef struct packed {
		logic fmt;
		logic place;
	} alloc_cmd_t;

	// Space answers from the allocator for the current request size.
	typedef struct packed {
		logic fits;
		logic room;
	} alloc_sts_t;

endpackage

// ----- sv/slotted_page_directory.sv -----
// Top level of the slotted page directory: sequencer, slot RAM and result register.
`timescale 1ns / 1ps
// A result loads in the execute state for most opcodes, in the place state for an update that
// moves its record, and for iter_next in the read state at the end or the check state on a hit.
// One beat at a time: the next is taken only once the result has loaded and the sequencer is back
// in idle; the walk reads the slot RAM in the read state and checks each entry in the check state.
// Reset clears count, floor (header size), ceiling (page size), iterator and own page index.
// The slot RAM is not cleared; only entries of slots below the record count are ever used.

module slotted_page_directory #(
	parameter int PAGE_BYTES   = 4096,
	parameter int HEADER_BYTES = 8,
	parameter int MAX_SLOTS    = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [spd_pkg::PAGE_W-1:0]        cfg_wdata,
	// request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [spd_pkg::OP_W-1:0]          opcode,
	input  logic [spd_pkg::PAGE_W-1:0]        request_page,
	input  logic [spd_pkg::SLOT_IN_W-1:0]     request_slot,
	input  logic [spd_pkg::SIZE_W-1:0]        request_size,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [spd_pkg::STATUS_W-1:0]      status,
	output logic [spd_pkg::SLOT_IN_W-1:0]     result_slot,
	output logic [spd_pkg::SIZE_W-1:0]        data_offset,
	output logic [spd_pkg::SIZE_W-1:0]        data_length,
	output logic                              fits,
	output logic                              found
);
	import spd_pkg::*;

	localparam int SLOT_W = $clog2(MAX_SLOTS);
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int OFF_W  = $clog2(PAGE_BYTES + 1);
	// A slot entry is {offset, size, used}.
	localparam int ENT_W  = OFF_W + SIZE_W + 1;
	// Common width for comparing slot numbers, iterator positions and the count.
	localparam int W_A    = (CNT_W > ITER_W) ? CNT_W : ITER_W;
	localparam int WIDE_W = (W_A > SLOT_IN_W) ? W_A : SLOT_IN_W;

	// Control state.
	state_t state_q, state_d;
	logic   out_valid_q;

	// The request beat is captured at acceptance and held for its whole run.
	logic [OP_W-1:0]      op_q;
	logic [PAGE_W-1:0]    page_q;
	logic [SLOT_IN_W-1:0] slot_q;
	logic [SIZE_W-1:0]    size_q;
	logic [PAGE_W-1:0]    own_q;
	logic [ITER_W-1:0]    iter_pos_q;
	logic [WIDE_W-1:0]    it_q;

	// Result register; it lets the sequencer go back to idle while a result waits.
	logic [STATUS_W-1:0]  status_q;
	logic [SLOT_IN_W-1:0] rslot_q;
	logic [SIZE_W-1:0]    roff_q;
	logic [SIZE_W-1:0]    rlen_q;
	logic                 fits_q;
	logic                 found_q;

	// The slot table lives in one synchronous RAM with a registered read.
	logic [ENT_W-1:0]  slot_mem [MAX_SLOTS];
	logic [ENT_W-1:0]  rdata_q;
	logic              rd_en;
	logic [SLOT_W-1:0] raddr;
	logic              mem_we;
	logic [SLOT_W-1:0] waddr;
	logic [ENT_W-1:0]  wdata;

	// Allocator interface.
	alloc_cmd_t        acmd;
	alloc_sts_t        asts;
	logic [CNT_W-1:0]  count;
	logic [OFF_W-1:0]  place_off;

	// Sequencer decisions.
	logic                 accept;
	logic                 out_free;
	logic                 fin;
	logic                 go_place;
	logic                 go_chk;
	logic                 go_rd;
	logic                 it_step;
	logic                 iter_clr;
	logic                 iter_set;
	logic [STATUS_W-1:0]  r_status;
	logic [SLOT_IN_W-1:0] r_slot;
	logic [SIZE_W-1:0]    r_off;
	logic [SIZE_W-1:0]    r_len;
	logic                 r_fits;
	logic                 r_found;

	// Decoded fields of the slot entry that was last read.
	logic                 ent_used;
	logic [SIZE_W-1:0]    ent_size;
	logic [OFF_W-1:0]     ent_off;
	logic                 size_eq;
	logic                 id_page_err;
	logic                 id_range_err;
	logic                 it_in;
	logic [ITER_W-1:0]    it_start;
	logic [ITER_W-1:0]    it_sat;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	assign ent_used  = rdata_q[0];
	assign ent_size  = rdata_q[SIZE_W:1];
	assign ent_off   = rdata_q[ENT_W-1:SIZE_W+1];
	assign size_eq   = (ent_size == size_q);

	// Id checks of get, get_size, delete and update. A slot below the count is
	// always below the table depth, so one compare covers both range limits.
	assign id_page_err  = (page_q != own_q);
	assign id_range_err = (WIDE_W'(slot_q) >= WIDE_W'(count));

	// The walk stays inside the directory while the position is below the count.
	assign it_in  = (it_q < WIDE_W'(count));
	assign it_sat = (it_q > WIDE_W'(ITER_LAST)) ? ITER_LAST : ITER_W'(it_q);

	always_comb begin
		if (iter_pos_q == ITER_BEFORE) begin
			it_start = '0;
		end else if (iter_pos_q >= ITER_LAST) begin
			it_start = ITER_LAST;
		end else begin
			it_start = iter_pos_q + ITER_W'(1);
		end
	end

	spd_alloc #(
		.PAGE_BYTES   (PAGE_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.MAX_SLOTS    (MAX_SLOTS)
	) u_alloc (
		.clk       (clk),
		.arst_n    (arst_n),
		.size      (size_q),
		.cmd       (acmd),
		.sts       (asts),
		.count     (count),
		.place_off (place_off)
	);

	// Action block. Every side effect of a finishing step waits until the result
	// register is free, so a stalled result never repeats a table or header update.
	always_comb begin
		fin      = 1'b0;
		go_place = 1'b0;
		go_chk   = 1'b0;
		go_rd    = 1'b0;
		it_step  = 1'b0;
		iter_clr = 1'b0;
		iter_set = 1'b0;
		r_status = ST_OK;
		r_slot   = '0;
		r_off    = '0;
		r_len    = '0;
		r_fits   = 1'b0;
		r_found  = 1'b0;
		acmd     = '0;
		rd_en    = 1'b0;
		raddr    = SLOT_W'(request_slot);
		mem_we   = 1'b0;
		waddr    = SLOT_W'(count);
		wdata    = {place_off, size_q, 1'b1};

		case (state_q)
			S_IDLE: begin
				// The addressed entry is fetched while the beat is taken.
				rd_en = accept;
			end
			S_EXEC: begin
				case (op_q)
					OP_FORMAT: begin
						fin       = 1'b1;
						acmd.fmt  = out_free;
						iter_clr  = 1'b1;
					end
					OP_CAN_FIT: begin
						fin    = 1'b1;
						r_fits = asts.fits;
					end
					OP_INSERT: begin
						fin = 1'b1;
						if (asts.room) begin
							acmd.place = out_free;
							mem_we     = out_free;
							r_slot     = SLOT_IN_W'(count);
							r_off      = SIZE_W'(place_off);
							r_len      = size_q;
						end else begin
							r_status = ST_SPACE;
						end
					end
					OP_GET, OP_GET_SIZE, OP_DELETE, OP_UPDATE: begin
						if (id_page_err) begin
							fin      = 1'b1;
							r_status = ST_PAGE;
						end else if (id_range_err) begin
							fin      = 1'b1;
							r_status = ST_RANGE;
						end else if (op_q != OP_GET_SIZE && !ent_used) begin
							fin      = 1'b1;
							r_status = ST_UNUSED;
						end else if (op_q == OP_GET && !size_eq) begin
							fin      = 1'b1;
							r_status = ST_SIZE;
						end else if (op_q == OP_UPDATE && !size_eq) begin
							if (!asts.room) begin
								fin      = 1'b1;
								r_status = ST_SPACE;
							end else begin
								// Retire the old slot now; the new one is placed in the place state.
								go_place = 1'b1;
								mem_we   = 1'b1;
								waddr    = SLOT_W'(slot_q);
								wdata    = {rdata_q[ENT_W-1:1], 1'b0};
							end
						end else begin
							fin    = 1'b1;
							r_slot = slot_q;
							r_off  = SIZE_W'(ent_off);
							r_len  = ent_size;
							if (op_q == OP_DELETE) begin
								mem_we = out_free;
								waddr  = SLOT_W'(slot_q);
								wdata  = {rdata_q[ENT_W-1:1], 1'b0};
							end
						end
					end
					OP_ITER_RESET: begin
						fin      = 1'b1;
						iter_clr = 1'b1;
					end
					default: begin
						// Unknown opcodes change nothing and answer with all fields zero.
						fin = 1'b1;
					end
				endcase
			end
			S_PLACE: begin
				fin        = 1'b1;
				acmd.place = out_free;
				mem_we     = out_free;
				r_slot     = SLOT_IN_W'(count);
				r_off      = SIZE_W'(place_off);
				r_len      = size_q;
			end
			S_ITRD: begin
				if (it_in) begin
					go_chk = 1'b1;
					rd_en  = 1'b1;
					raddr  = SLOT_W'(it_q);
				end else begin
					fin      = 1'b1;
					iter_set = 1'b1;
				end
			end
			S_ITCHK: begin
				if (ent_used) begin
					fin      = 1'b1;
					iter_set = 1'b1;
					r_found  = 1'b1;
					r_slot   = SLOT_IN_W'(it_q);
					r_off    = SIZE_W'(ent_off);
					r_len    = ent_size;
				end else begin
					go_rd   = 1'b1;
					it_step = 1'b1;
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// Next-state block.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (opcode == OP_ITER_NEXT) ? S_ITRD : S_EXEC;
				end
			end
			S_EXEC, S_PLACE: begin
				if (go_place) begin
					state_d = S_PLACE;
				end else if (fin && out_free) begin
					state_d = S_IDLE;
				end
			end
			S_ITRD: begin
				if (go_chk) begin
					state_d = S_ITCHK;
				end else if (fin && out_free) begin
					state_d = S_IDLE;
				end
			end
			S_ITCHK: begin
				if (go_rd) begin
					state_d = S_ITRD;
				end else if (fin && out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			own_q       <= '0;
			iter_pos_q  <= ITER_BEFORE;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				own_q <= cfg_wdata;
			end
			if (fin && out_free) begin
				out_valid_q <= 1'b1;
				if (iter_clr) begin
					iter_pos_q <= ITER_BEFORE;
				end else if (iter_set) begin
					iter_pos_q <= it_sat;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request capture, walk position and result payload need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			page_q <= request_page;
			slot_q <= request_slot;
			size_q <= request_size;
			it_q   <= WIDE_W'(it_start);
		end else if (it_step) begin
			it_q <= it_q + WIDE_W'(1);
		end
		if (fin && out_free) begin
			status_q <= r_status;
			rslot_q  <= r_slot;
			roff_q   <= r_off;
			rlen_q   <= r_len;
			fits_q   <= r_fits;
			found_q  <= r_found;
		end
	end

	// Slot RAM: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= slot_mem[raddr];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign result_slot = rslot_q;
	assign data_offset = roff_q;
	assign data_length = rlen_q;
	assign fits        = fits_q;
	assign found       = found_q;

	// The directory never holds more records than it has slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(MAX_SLOTS))
		else $error("record count exceeds slot capacity");

	// A found slot from the walk is always reported as a clean result.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && found_q) |-> (status_q == ST_OK))
		else $error("iteration hit carries an error status");

	// The sequencer only leaves idle on an accepted request beat.
	a_start_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && $past(state_q) == S_IDLE) |-> $past(in_valid))
		else $error("sequencer started without a request beat");

endmodule

// ----- sv/spd_alloc.sv -----
// Page header registers (record count, floor, ceiling) and the space check.
`timescale 1ns / 1ps

module spd_alloc #(
	parameter int PAGE_BYTES   = 4096,
	parameter int HEADER_BYTES = 8,
	parameter int MAX_SLOTS    = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [spd_pkg::SIZE_W-1:0]          size,
	input  spd_pkg::alloc_cmd_t                 cmd,
	output spd_pkg::alloc_sts_t                 sts,
	output logic [$clog2(MAX_SLOTS+1)-1:0]      count,
	output logic [$clog2(PAGE_BYTES+1)-1:0]     place_off
);
	import spd_pkg::*;

	localparam int CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int OFF_W = $clog2(PAGE_BYTES + 1);
	localparam int CMP_W = ((OFF_W > SIZE_W + 1) ? OFF_W : SIZE_W + 1) + 1;

	logic [CNT_W-1:0]  count_q;
	logic [OFF_W-1:0]  floor_q;
	logic [OFF_W-1:0]  ceil_q;
	logic [OFF_W-1:0]  gap;
	logic [SIZE_W:0]   need;

	// The floor never passes the ceiling, so the gap is never negative, and a
	// gap that holds size plus one slot also implies size is within the ceiling.
	assign gap       = ceil_q - floor_q;
	assign need      = {1'b0, size} + (SIZE_W + 1)'(SLOT_BYTES);
	assign sts.fits  = CMP_W'(gap) >= CMP_W'(need);
	assign sts.room  = sts.fits && (count_q < CNT_W'(MAX_SLOTS));
	assign place_off = ceil_q - OFF_W'(size);
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			floor_q <= OFF_W'(HEADER_BYTES);
			ceil_q  <= OFF_W'(PAGE_BYTES);
		end else if (cmd.fmt) begin
			count_q <= '0;
			floor_q <= OFF_W'(HEADER_BYTES);
			ceil_q  <= OFF_W'(PAGE_BYTES);
		end else if (cmd.place) begin
			count_q <= count_q + CNT_W'(1);
			floor_q <= floor_q + OFF_W'(SLOT_BYTES);
			ceil_q  <= place_off;
		end
	end

endmodule

// ----- tb/sv/slotted_page_directory_checker.sv -----
// Checker for the slotted page directory: predicts each result beat and compares it.
`timescale 1ns / 1ps

module slotted_page_directory_checker #(
	parameter int PAGE_BYTES   = 4096,
	parameter int HEADER_BYTES = 8,
	parameter int MAX_SLOTS    = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [spd_pkg::PAGE_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [spd_pkg::OP_W-1:0]      opcode,
	input  logic [spd_pkg::PAGE_W-1:0]    request_page,
	input  logic [spd_pkg::SLOT_IN_W-1:0] request_slot,
	input  logic [spd_pkg::SIZE_W-1:0]    request_size,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [spd_pkg::STATUS_W-1:0]  status,
	input  logic [spd_pkg::SLOT_IN_W-1:0] result_slot,
	input  logic [spd_pkg::SIZE_W-1:0]    data_offset,
	input  logic [spd_pkg::SIZE_W-1:0]    data_length,
	input  logic                          fits,
	input  logic                          found,
	output int                            fail_count,
	output int                            pending
);
	import spd_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [SLOT_IN_W-1:0] slot;
		logic [SIZE_W-1:0]    offset;
		logic [SIZE_W-1:0]    length;
		logic                 fits;
		logic                 found;
	} dir_result_t;

	// Shadow of the page header and slot directory.
	logic [PAGE_W-1:0] own_page;
	logic [10:0]       rec_count;
	logic [SIZE_W-1:0] floor_ofs;
	logic [SIZE_W-1:0] ceil_ofs;
	logic [ITER_W-1:0] iter_pos;
	bit                slot_used [MAX_SLOTS];
	logic [14:0]       slot_len  [MAX_SLOTS];
	logic [15:0]       slot_ofs  [MAX_SLOTS];

	dir_result_t expected_results [$];
	dir_result_t head;

	function automatic void wipe_page();
		rec_count = '0;
		floor_ofs = SIZE_W'(HEADER_BYTES);
		ceil_ofs  = SIZE_W'(PAGE_BYTES);
		iter_pos  = ITER_BEFORE;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			slot_used[i] = 1'b0;
			slot_len[i]  = '0;
			slot_ofs[i]  = '0;
		end
	endfunction

	function automatic bit room_for(int sz);
		return sz <= int'(ceil_ofs) && int'(rec_count) < MAX_SLOTS &&
			int'(ceil_ofs) - sz >= int'(floor_ofs) + SLOT_BYTES;
	endfunction

	// Takes the next slot and moves the ceiling down by the record size.
	function automatic dir_result_t place_record(int sz);
		dir_result_t r;
		int          off;
		r = '0;
		off = int'(ceil_ofs) - sz;
		slot_used[rec_count] = 1'b1;
		slot_len[rec_count]  = 15'(sz);
		slot_ofs[rec_count]  = 16'(off);
		r.slot   = rec_count[SLOT_IN_W-1:0];
		r.offset = SIZE_W'(off);
		r.length = SIZE_W'(sz);
		rec_count = rec_count + 11'd1;
		floor_ofs = floor_ofs + SIZE_W'(SLOT_BYTES);
		ceil_ofs  = SIZE_W'(off);
		return r;
	endfunction

	function automatic dir_result_t apply_request(logic [OP_W-1:0] op, logic [PAGE_W-1:0] page,
			logic [SLOT_IN_W-1:0] slot, logic [SIZE_W-1:0] size);
		dir_result_t r;
		int          idx;
		r = '0;
		case (op)
			OP_FORMAT: wipe_page();
			OP_CAN_FIT: r.fits = (int'(ceil_ofs) - int'(floor_ofs)) >= int'(size) + SLOT_BYTES;
			OP_INSERT: begin
				if (room_for(int'(size)))
					r = place_record(int'(size));
				else
					r.status = ST_SPACE;
			end
			OP_GET, OP_GET_SIZE, OP_DELETE, OP_UPDATE: begin
				if (page != own_page)
					r.status = ST_PAGE;
				else if (int'(slot) >= int'(rec_count) || int'(slot) >= MAX_SLOTS)
					r.status = ST_RANGE;
				else if (op != OP_GET_SIZE && !slot_used[slot])
					r.status = ST_UNUSED;
				else if (op == OP_GET && int'(slot_len[slot]) != int'(size))
					r.status = ST_SIZE;
				else if (op == OP_UPDATE && int'(slot_len[slot]) != int'(size)) begin
					if (!room_for(int'(size)))
						r.status = ST_SPACE;
					else begin
						slot_used[slot] = 1'b0;
						r = place_record(int'(size));
					end
				end else begin
					if (op == OP_DELETE)
						slot_used[slot] = 1'b0;
					r.slot   = slot;
					r.offset = slot_ofs[slot][SIZE_W-1:0];
					r.length = slot_len[slot][SIZE_W-1:0];
				end
			end
			OP_ITER_RESET: iter_pos = ITER_BEFORE;
			OP_ITER_NEXT: begin
				if (iter_pos == ITER_BEFORE)
					idx = 0;
				else if (iter_pos >= ITER_LAST)
					idx = int'(ITER_LAST);
				else
					idx = int'(iter_pos) + 1;
				while (idx < int'(rec_count) && idx < MAX_SLOTS && !slot_used[idx])
					idx++;
				if (idx < int'(rec_count) && idx < MAX_SLOTS) begin
					r.slot   = SLOT_IN_W'(idx);
					r.offset = slot_ofs[idx][SIZE_W-1:0];
					r.length = slot_len[idx][SIZE_W-1:0];
					r.found  = 1'b1;
				end
				iter_pos = (idx > int'(ITER_LAST)) ? ITER_LAST : ITER_W'(idx);
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_page = '0;
			wipe_page();
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t ns: result beat with nothing expected, got status %0d slot %0d",
						$time, status, result_slot);
					fail_count++;
				end else begin
					head = expected_results.pop_front();
					check_field("status", 32'(head.status), 32'(status));
					check_field("result_slot", 32'(head.slot), 32'(result_slot));
					check_field("data_offset", 32'(head.offset), 32'(data_offset));
					check_field("data_length", 32'(head.length), 32'(data_length));
					check_field("fits", 32'(head.fits), 32'(fits));
					check_field("found", 32'(head.found), 32'(found));
				end
			end
			if (in_valid && !in_stall)
				expected_results.push_back(apply_request(opcode, request_page, request_slot,
					request_size));
			if (cfg_we)
				own_page = cfg_wdata;
		end
		pending = expected_results.size();
	end

endmodule

// ----- tb/sv/slotted_page_directory_tb.sv -----
// Testbench top for the slotted page directory: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module slotted_page_directory_tb;
	import spd_pkg::*;

	// Far above the slowest legal run: every beat waiting out the longest sender gap,
	// the longest receiver stall and a full directory walk still ends well before this.
	localparam int CYCLE_LIMIT = 10_000_000;

	// Length of the deliberate receiver hold-off that backs the block up.
	localparam int HOLD_CYCLES = 400;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [PAGE_W-1:0]    cfg_wdata;
	logic                 in_valid;
	logic                 in_stall;
	logic [OP_W-1:0]      opcode;
	logic [PAGE_W-1:0]    request_page;
	logic [SLOT_IN_W-1:0] request_slot;
	logic [SIZE_W-1:0]    request_size;
	logic                 out_valid;
	logic                 out_stall;
	logic [STATUS_W-1:0]  status;
	logic [SLOT_IN_W-1:0] result_slot;
	logic [SIZE_W-1:0]    data_offset;
	logic [SIZE_W-1:0]    data_length;
	logic                 fits;
	logic                 found;

	int fail_count;
	int pending;
	int cycle_count = 0;

	// Idle percentages of the two sides; the stimulus changes them per phase.
	int send_idle_pct;
	int rcv_stall_pct;

	// The stimulus asks for a hold-off by bumping hold_asked; the receiver
	// process serves it and bumps hold_served, so each counter has one writer.
	int hold_asked;
	int hold_served;

	// The page index the block currently owns, so most requests can name it.
	logic [PAGE_W-1:0] page_index;

	always #6 clk = ~clk;

	slotted_page_directory dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.request_page (request_page),
		.request_slot (request_slot),
		.request_size (request_size),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.result_slot  (result_slot),
		.data_offset  (data_offset),
		.data_length  (data_length),
		.fits         (fits),
		.found        (found)
	);

	slotted_page_directory_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.request_page (request_page),
		.request_slot (request_slot),
		.request_size (request_size),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.result_slot  (result_slot),
		.data_offset  (data_offset),
		.data_length  (data_length),
		.fits         (fits),
		.found        (found),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// A hung block never drains its beats; the cycle counter catches that.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Result side. Stall changes only at the falling edge. A requested hold-off keeps
	// stall high for a fixed stretch counted here, while the sender keeps offering beats.
	initial begin
		out_stall = 1'b0;
		hold_served = 0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_asked) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_served++;
			end
			out_stall = ($urandom_range(99) < rcv_stall_pct);
		end
	end

	// Offers one request beat from a falling edge and returns at the falling edge after
	// the rising edge that took it. A random gap may come first when the sender idles.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] page,
			input logic [SLOT_IN_W-1:0] slot, input logic [SIZE_W-1:0] size);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid     = 1'b1;
		opcode       = op;
		request_page = page;
		request_slot = slot;
		request_size = size;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Sizes lean on a small set of values so that get and update often match the
	// stored size, with some wide and out-of-page sizes mixed in.
	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(9))
			0: return '0;
			1: return SIZE_W'(1);
			2: return SIZE_W'(16);
			3: return SIZE_W'(64);
			4: return SIZE_W'(100);
			5: return SIZE_W'(255);
			6: return SIZE_W'($urandom_range(600));
			7: return SIZE_W'($urandom_range(4096));
			8: return SIZE_W'($urandom);
			default: return SIZE_W'(4096);
		endcase
	endfunction

	// Mostly well-formed requests: the owned page and a slot index that a page
	// of small records can reach. The rest carry a foreign page or any slot.
	task automatic random_request();
		int                   pick;
		logic [OP_W-1:0]      op;
		logic [PAGE_W-1:0]    page;
		logic [SLOT_IN_W-1:0] slot;
		pick = $urandom_range(99);
		if (pick < 3)
			op = OP_FORMAT;
		else if (pick < 11)
			op = OP_CAN_FIT;
		else if (pick < 36)
			op = OP_INSERT;
		else if (pick < 51)
			op = OP_GET;
		else if (pick < 58)
			op = OP_GET_SIZE;
		else if (pick < 68)
			op = OP_DELETE;
		else if (pick < 80)
			op = OP_UPDATE;
		else if (pick < 84)
			op = OP_ITER_RESET;
		else if (pick < 97)
			op = OP_ITER_NEXT;
		else
			op = OP_W'($urandom_range(int'(OP_ITER_NEXT) + 1, 15));
		page = ($urandom_range(99) < 85) ? page_index : PAGE_W'($urandom);
		slot = ($urandom_range(99) < 85) ? SLOT_IN_W'($urandom_range(47))
			: SLOT_IN_W'($urandom);
		send_request(op, page, slot, pick_size());
	endtask

	task automatic run_phase(input int beats, input int send_pct, input int rcv_pct);
		send_idle_pct = send_pct;
		rcv_stall_pct = rcv_pct;
		repeat (beats) random_request();
		in_valid = 1'b0;
	endtask

	// Waits until every expected result beat has been taken, then a few more cycles.
	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// The page index is only written while the block is idle.
	task automatic write_page_index(input logic [PAGE_W-1:0] value);
		drain();
		cfg_we     = 1'b1;
		cfg_wdata  = value;
		page_index = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		in_valid      = 1'b0;
		opcode        = OP_FORMAT;
		request_page  = '0;
		request_slot  = '0;
		request_size  = '0;
		send_idle_pct = 0;
		rcv_stall_pct = 0;
		hold_asked    = 0;
		page_index    = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part with the all-ones page index and no idling on either side.
		write_page_index('1);
		send_request(OP_ITER_NEXT, page_index, '0, '0);      // empty page, nothing found
		send_request(OP_CAN_FIT, page_index, '0, 13'd4084);  // exactly fits the empty page
		send_request(OP_CAN_FIT, page_index, '0, 13'd4085);  // one byte too many
		send_request(OP_INSERT, page_index, '0, '1);         // larger than the ceiling
		send_request(OP_GET, page_index, '0, '0);            // no slots yet
		send_request(OP_INSERT, page_index, '0, '0);         // zero-length record
		send_request(OP_INSERT, page_index, '0, 13'd100);
		send_request(OP_GET, '0, 10'd1, 13'd100);            // names a foreign page
		send_request(OP_GET, page_index, 10'd1, 13'd100);
		send_request(OP_GET, page_index, 10'd1, 13'd99);     // size does not match
		send_request(OP_DELETE, page_index, '0, '0);
		send_request(OP_GET, page_index, '0, '0);            // slot no longer in use
		send_request(OP_GET_SIZE, page_index, '0, '0);       // ignores the used flag
		send_request(OP_DELETE, page_index, '0, '0);         // second delete of the slot
		send_request(OP_UPDATE, page_index, 10'd1, 13'd100); // same size stays in place
		send_request(OP_UPDATE, page_index, 10'd1, 13'd4000);// no room, old slot kept
		send_request(OP_UPDATE, page_index, 10'd1, 13'd50);  // moves to a new slot
		send_request(OP_GET, page_index, '1, '0);            // highest slot index
		send_request(OP_ITER_RESET, page_index, '0, '0);
		send_request(OP_ITER_NEXT, page_index, '0, '0);      // skips two unused slots
		send_request(OP_ITER_NEXT, page_index, '0, '0);      // runs off the end
		send_request(4'd15, '1, '1, '1);                     // unknown opcode
		send_request(OP_INSERT, page_index, '0, 13'd3922);   // fills the gap exactly
		send_request(OP_INSERT, page_index, '0, '0);         // slot entry no longer fits
		send_request(OP_CAN_FIT, page_index, '0, '0);
		send_request(OP_FORMAT, page_index, '0, '0);
		send_request(OP_ITER_NEXT, page_index, '0, '0);      // empty again after format
		in_valid = 1'b0;

		// Random part, one page index per phase, with the idling varied between phases.
		run_phase(170, 0, 0);
		write_page_index('0);
		run_phase(170, 69, 0);
		write_page_index(PAGE_W'($urandom));
		run_phase(170, 0, 69);
		write_page_index(PAGE_W'($urandom));

		// Back-pressure: the receiver holds off while the sender keeps offering beats.
		hold_asked++;
		run_phase(15, 0, 0);
		run_phase(170, 28, 28);

		drain();
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- slotted_page_directory.f -----
sv/spd_pkg.sv
sv/spd_alloc.sv
sv/slotted_page_directory.sv
tb/sv/slotted_page_directory_checker.sv
tb/sv/slotted_page_directory_tb.sv
